// ===== rtl/v3a_pkg.sv =====
package v3a_pkg;

	localparam int WORD_W = 32;
	localparam int FRAC_W = 16;
	localparam int LANES  = 3;
	localparam int PROD_W = 2 * WORD_W;
	localparam int ACC_W  = PROD_W + 2;
	localparam int NUM_W  = WORD_W + FRAC_W;
	localparam int SQ_W   = PROD_W;
	localparam int ROOT_W = SQ_W / 2;
	localparam int CMD_W  = 4;

	localparam logic [CMD_W-1:0] CMD_ADD   = 4'd0;
	localparam logic [CMD_W-1:0] CMD_SUB   = 4'd1;
	localparam logic [CMD_W-1:0] CMD_MUL   = 4'd2;
	localparam logic [CMD_W-1:0] CMD_DIV   = 4'd3;
	localparam logic [CMD_W-1:0] CMD_SCALE = 4'd4;
	localparam logic [CMD_W-1:0] CMD_SDIV  = 4'd5;
	localparam logic [CMD_W-1:0] CMD_NEG   = 4'd6;
	localparam logic [CMD_W-1:0] CMD_DOT   = 4'd7;
	localparam logic [CMD_W-1:0] CMD_CROSS = 4'd8;
	localparam logic [CMD_W-1:0] CMD_LEN   = 4'd9;
	localparam logic [CMD_W-1:0] CMD_NORM  = 4'd10;
	localparam logic [CMD_W-1:0] CMD_EQ    = 4'd11;

	typedef logic signed [WORD_W-1:0] word_t;

	localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	// clamp a wide signed value to the word range
	function automatic word_t sat_acc(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-WORD_W:0] upper;
		upper = v[ACC_W-1:WORD_W-1];
		if ((&upper) || !(|upper))
			return v[WORD_W-1:0];
		else if (v[ACC_W-1])
			return WORD_MIN;
		else
			return WORD_MAX;
	endfunction

endpackage

// ===== rtl/v3a_in_if.sv =====
interface v3a_in_if import v3a_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CMD_W-1:0]      cmd;
	logic signed [WORD_W-1:0] a_x;
	logic signed [WORD_W-1:0] a_y;
	logic signed [WORD_W-1:0] a_z;
	logic signed [WORD_W-1:0] b_x;
	logic signed [WORD_W-1:0] b_y;
	logic signed [WORD_W-1:0] b_z;
	logic signed [WORD_W-1:0] scalar_in;

	modport source (output valid, cmd, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in, input ready);
	modport sink (input valid, cmd, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in, output ready);
endinterface

// ===== rtl/v3a_out_if.sv =====
interface v3a_out_if import v3a_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic signed [WORD_W-1:0] res_x;
	logic signed [WORD_W-1:0] res_y;
	logic signed [WORD_W-1:0] res_z;
	logic signed [WORD_W-1:0] res_scalar;
	logic                  is_equal;
	logic                  div_zero;

	modport source (output valid, res_x, res_y, res_z, res_scalar, is_equal, div_zero,
		input ready);
	modport sink (input valid, res_x, res_y, res_z, res_scalar, is_equal, div_zero,
		output ready);
endinterface

// ===== rtl/v3a_sqrt.sv =====
module v3a_sqrt import v3a_pkg::*; #(
	parameter int TAG_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_i,
	input  logic [SQ_W-1:0]   rad_i,
	input  logic [TAG_W-1:0]  tag_i,
	output logic              vld_o,
	output logic [ROOT_W-1:0] root_o,
	output logic [TAG_W-1:0]  tag_o
);

	// one result bit per stage
	logic [SQ_W-1:0]  rem_s [ROOT_W];
	logic [SQ_W-1:0]  res_s [ROOT_W];
	logic             vld_s [ROOT_W];
	logic [TAG_W-1:0] tag_s [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_st
		localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (SQ_W - 2 - 2 * k);
		logic [SQ_W-1:0]  rem_p;
		logic [SQ_W-1:0]  res_p;
		logic [SQ_W-1:0]  trial;
		logic             vld_p;
		logic [TAG_W-1:0] tag_p;

		if (k == 0) begin : g_first
			assign rem_p = rad_i;
			assign res_p = '0;
			assign vld_p = vld_i;
			assign tag_p = tag_i;
		end else begin : g_next
			assign rem_p = rem_s[k-1];
			assign res_p = res_s[k-1];
			assign vld_p = vld_s[k-1];
			assign tag_p = tag_s[k-1];
		end

		assign trial = res_p + BITV;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (en)
				vld_s[k] <= vld_p;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[k] <= tag_p;
				if (rem_p >= trial) begin
					rem_s[k] <= rem_p - trial;
					res_s[k] <= (res_p >> 1) + BITV;
				end else begin
					rem_s[k] <= rem_p;
					res_s[k] <= res_p >> 1;
				end
			end
		end
	end

	assign vld_o  = vld_s[ROOT_W-1];
	assign root_o = res_s[ROOT_W-1][ROOT_W-1:0];
	assign tag_o  = tag_s[ROOT_W-1];

endmodule

// ===== rtl/v3a_div.sv =====
module v3a_div import v3a_pkg::*; #(
	parameter int TAG_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_i,
	input  logic [NUM_W-1:0]  num_i [LANES],
	input  logic [WORD_W-1:0] den_i [LANES],
	input  logic [TAG_W-1:0]  tag_i,
	output logic              vld_o,
	output logic [NUM_W-1:0]  quo_o [LANES],
	output logic [TAG_W-1:0]  tag_o
);

	// restoring division, one quotient bit per stage, three lanes side by side
	logic [WORD_W-1:0] rem_s [NUM_W][LANES];
	logic [NUM_W-1:0]  nq_s  [NUM_W][LANES];
	logic [WORD_W-1:0] den_s [NUM_W][LANES];
	logic              vld_s [NUM_W];
	logic [TAG_W-1:0]  tag_s [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_st
		if (k == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					vld_s[k] <= 1'b0;
				else if (en)
					vld_s[k] <= vld_i;
			end
			always_ff @(posedge clk) begin
				if (en)
					tag_s[k] <= tag_i;
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					vld_s[k] <= 1'b0;
				else if (en)
					vld_s[k] <= vld_s[k-1];
			end
			always_ff @(posedge clk) begin
				if (en)
					tag_s[k] <= tag_s[k-1];
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [WORD_W-1:0] rem_p;
			logic [WORD_W-1:0] den_p;
			logic [NUM_W-1:0]  nq_p;
			logic [WORD_W:0]   part;
			logic              ge;

			if (k == 0) begin : g_first
				assign rem_p = '0;
				assign nq_p  = num_i[l];
				assign den_p = den_i[l];
			end else begin : g_next
				assign rem_p = rem_s[k-1][l];
				assign nq_p  = nq_s[k-1][l];
				assign den_p = den_s[k-1][l];
			end

			assign part = {rem_p, nq_p[NUM_W-1]};
			assign ge   = part >= {1'b0, den_p};

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k][l] <= ge ? WORD_W'(part - {1'b0, den_p}) : part[WORD_W-1:0];
					nq_s[k][l]  <= {nq_p[NUM_W-2:0], ge};
					den_s[k][l] <= den_p;
				end
			end

			if (k == NUM_W - 1) begin : g_out
				assign quo_o[l] = nq_s[k][l];
			end
		end
	end

	assign vld_o = vld_s[NUM_W-1];
	assign tag_o = tag_s[NUM_W-1];

endmodule

// ===== rtl/vec3_alu.sv =====
// Three-component vector unit, signed Q16.16.
//
// Channels: req (sink) carries cmd, vectors a and b and scalar_in; rsp (source)
// returns res_x/y/z, res_scalar, is_equal and div_zero. A transaction moves on a
// rising edge with valid and ready both high. Every request gives one response.
//
// Stages: a request passes through the input register, multiply stage,
// combine/saturate stage, 32 square-root stages (one root bit each), 48
// divider stages (one quotient bit each) and the output register. Every
// operation takes the same path so order is kept.
//
// Throughput: one transaction per cycle. The pipeline moves as one piece; it
// advances whenever the output register is empty or being taken.
// When the receiver holds rsp.ready low with a response waiting, the whole
// pipeline freezes and req.ready drops; nothing is dropped or repeated.
//
// Reset: arst_n clears all valid bits at once; the pipeline is empty after it.
module vec3_alu import v3a_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	v3a_in_if.sink    req,
	v3a_out_if.source rsp
);

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		word_t [LANES-1:0]   a;
		word_t [LANES-1:0]   b;
		word_t               sc;
		word_t [LANES-1:0]   rv;
		word_t               rs;
		logic                eq;
	} mid_t;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		word_t [LANES-1:0]   rv;
		word_t               rs;
		logic                eq;
		logic [LANES-1:0]    qneg;
		logic [LANES-1:0]    dz;
		logic [LANES-1:0]    aneg;
		logic [LANES-1:0]    anz;
	} post_t;

	localparam int MID_W  = $bits(mid_t);
	localparam int POST_W = $bits(post_t);
	localparam logic [NUM_W-1:0] QNEG_LIM = NUM_W'(1) << (WORD_W - 1);
	localparam logic [NUM_W-1:0] QPOS_LIM = QNEG_LIM - NUM_W'(1);

	logic en;

	// stage 1: input register
	logic             vld_s1;
	logic [CMD_W-1:0] cmd_s1;
	word_t            a_s1 [LANES];
	word_t            b_s1 [LANES];
	word_t            sc_s1;

	// stage 2: products
	logic             vld_s2;
	logic [CMD_W-1:0] cmd_s2;
	word_t            a_s2 [LANES];
	word_t            b_s2 [LANES];
	word_t            sc_s2;
	logic signed [PROD_W-1:0] p_s2 [LANES];
	logic signed [PROD_W-1:0] q_s2 [LANES];

	// stage 3: combined and saturated, sum of squares for the root
	logic            vld_s3;
	mid_t            mid_s3;
	logic [SQ_W-1:0] sumsq_s3;

	word_t mx [LANES];
	word_t my [LANES];
	word_t mu [LANES];
	word_t mv [LANES];

	mid_t            mid_d;
	logic [SQ_W-1:0] sumsq_d;

	logic              sq_vld;
	logic [ROOT_W-1:0] sq_root;
	logic [MID_W-1:0]  sq_tag;
	mid_t              sq_mid;
	word_t             len_sat;

	post_t             post_d;
	logic [NUM_W-1:0]  num_d [LANES];
	logic [WORD_W-1:0] den_d [LANES];

	logic              dv_vld;
	logic [NUM_W-1:0]  quo [LANES];
	logic [POST_W-1:0] dv_tag;
	post_t             fp;

	word_t rv_f [LANES];
	logic  is_div;

	// output register
	logic             vld_o_q;
	logic [CMD_W-1:0] cmd_q;
	word_t            rv_q [LANES];
	word_t            rs_q;
	logic             eq_q;
	logic             dz_q;

	// the pipeline advances as a whole when the output slot is free or taken
	assign en        = !vld_o_q || rsp.ready;
	assign req.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= req.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1  <= req.cmd;
			a_s1[0] <= req.a_x;
			a_s1[1] <= req.a_y;
			a_s1[2] <= req.a_z;
			b_s1[0] <= req.b_x;
			b_s1[1] <= req.b_y;
			b_s1[2] <= req.b_z;
			sc_s1   <= req.scalar_in;
		end
	end

	// Multiplier operands. Lane i's first multiplier serves mul, scale, dot,
	// the squares for len/norm and the positive cross term; the second one
	// only the subtracted cross term.
	always_comb begin
		int j;
		int k;
		for (int i = 0; i < LANES; i++) begin
			j = (i + 1 == LANES) ? 0 : i + 1;
			k = (j + 1 == LANES) ? 0 : j + 1;
			mx[i] = a_s1[i];
			my[i] = b_s1[i];
			mu[i] = a_s1[k];
			mv[i] = b_s1[j];
			case (cmd_s1)
				CMD_SCALE: begin
					my[i] = sc_s1;
				end
				CMD_LEN, CMD_NORM: begin
					my[i] = a_s1[i];
				end
				CMD_CROSS: begin
					mx[i] = a_s1[j];
					my[i] = b_s1[k];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2 <= cmd_s1;
			sc_s2  <= sc_s1;
			for (int i = 0; i < LANES; i++) begin
				a_s2[i] <= a_s1[i];
				b_s2[i] <= b_s1[i];
				p_s2[i] <= mx[i] * my[i];
				q_s2[i] <= mu[i] * mv[i];
			end
		end
	end

	// Products drop their fraction by flooring (arithmetic shift) before
	// saturation; dot sums the three full products first.
	always_comb begin
		logic signed [ACC_W-1:0] ea;
		logic signed [ACC_W-1:0] eb;
		logic signed [ACC_W-1:0] pe;
		logic signed [ACC_W-1:0] qe;
		logic signed [ACC_W-1:0] dsum;
		dsum      = '0;
		sumsq_d   = '0;
		mid_d.cmd = cmd_s2;
		mid_d.sc  = sc_s2;
		mid_d.eq  = (cmd_s2 == CMD_EQ) && (a_s2[0] == b_s2[0]) &&
			(a_s2[1] == b_s2[1]) && (a_s2[2] == b_s2[2]);
		for (int i = 0; i < LANES; i++) begin
			mid_d.a[i] = a_s2[i];
			mid_d.b[i] = b_s2[i];
			ea = ACC_W'(a_s2[i]);
			eb = ACC_W'(b_s2[i]);
			pe = ACC_W'(p_s2[i]);
			qe = ACC_W'(q_s2[i]);
			dsum    = dsum + pe;
			sumsq_d = sumsq_d + SQ_W'(p_s2[i]);
			case (cmd_s2)
				CMD_ADD:            mid_d.rv[i] = sat_acc(ea + eb);
				CMD_SUB:            mid_d.rv[i] = sat_acc(ea - eb);
				CMD_MUL, CMD_SCALE: mid_d.rv[i] = sat_acc(pe >>> FRAC_W);
				CMD_NEG:            mid_d.rv[i] = sat_acc(-ea);
				CMD_CROSS:          mid_d.rv[i] = sat_acc((pe - qe) >>> FRAC_W);
				default:            mid_d.rv[i] = '0;
			endcase
		end
		mid_d.rs = (cmd_s2 == CMD_DOT) ? sat_acc(dsum >>> FRAC_W) : '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mid_s3   <= mid_d;
			sumsq_s3 <= sumsq_d;
		end
	end

	v3a_sqrt #(.TAG_W(MID_W)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s3),
		.rad_i  (sumsq_s3),
		.tag_i  (mid_s3),
		.vld_o  (sq_vld),
		.root_o (sq_root),
		.tag_o  (sq_tag)
	);

	assign sq_mid  = mid_t'(sq_tag);
	assign len_sat = sq_root[ROOT_W-1] ? WORD_MAX : word_t'(sq_root[WORD_W-1:0]);

	// Divider operands as magnitudes; signs and zero cases travel in the tag.
	// Norm divides by the unsaturated root, which is never negative.
	always_comb begin
		logic              dneg;
		logic [WORD_W-1:0] dmag;
		logic [WORD_W-1:0] amag;
		logic              aneg;
		post_d.cmd = sq_mid.cmd;
		post_d.rv  = sq_mid.rv;
		post_d.eq  = sq_mid.eq;
		post_d.rs  = (sq_mid.cmd == CMD_LEN || sq_mid.cmd == CMD_NORM) ? len_sat : sq_mid.rs;
		for (int i = 0; i < LANES; i++) begin
			case (sq_mid.cmd)
				CMD_DIV: begin
					dneg = sq_mid.b[i][WORD_W-1];
					dmag = dneg ? (~sq_mid.b[i] + 1'b1) : sq_mid.b[i];
				end
				CMD_SDIV: begin
					dneg = sq_mid.sc[WORD_W-1];
					dmag = dneg ? (~sq_mid.sc + 1'b1) : sq_mid.sc;
				end
				default: begin
					dneg = 1'b0;
					dmag = sq_root[WORD_W-1:0];
				end
			endcase
			aneg = sq_mid.a[i][WORD_W-1];
			amag = aneg ? (~sq_mid.a[i] + 1'b1) : sq_mid.a[i];
			num_d[i]       = {amag, {FRAC_W{1'b0}}};
			den_d[i]       = dmag;
			post_d.qneg[i] = aneg ^ dneg;
			post_d.dz[i]   = (dmag == '0);
			post_d.aneg[i] = aneg;
			post_d.anz[i]  = |sq_mid.a[i];
		end
	end

	v3a_div #(.TAG_W(POST_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (sq_vld),
		.num_i  (num_d),
		.den_i  (den_d),
		.tag_i  (post_d),
		.vld_o  (dv_vld),
		.quo_o  (quo),
		.tag_o  (dv_tag)
	);

	assign fp     = post_t'(dv_tag);
	assign is_div = (fp.cmd == CMD_DIV) || (fp.cmd == CMD_SDIV) || (fp.cmd == CMD_NORM);

	// quotient sign and saturation; a zero divisor gives the rail of the
	// dividend's sign, or zero for a zero dividend
	always_comb begin
		word_t qv;
		for (int i = 0; i < LANES; i++) begin
			if (fp.dz[i])
				qv = fp.anz[i] ? (fp.aneg[i] ? WORD_MIN : WORD_MAX) : '0;
			else if (fp.qneg[i])
				qv = (quo[i] > QNEG_LIM) ? WORD_MIN : (~quo[i][WORD_W-1:0] + 1'b1);
			else
				qv = (quo[i] > QPOS_LIM) ? WORD_MAX : quo[i][WORD_W-1:0];
			rv_f[i] = is_div ? qv : fp.rv[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_o_q <= 1'b0;
		else if (en)
			vld_o_q <= dv_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_q <= fp.cmd;
			for (int i = 0; i < LANES; i++)
				rv_q[i] <= rv_f[i];
			rs_q <= fp.rs;
			eq_q <= fp.eq;
			dz_q <= is_div && (|fp.dz);
		end
	end

	assign rsp.valid      = vld_o_q;
	assign rsp.res_x      = rv_q[0];
	assign rsp.res_y      = rv_q[1];
	assign rsp.res_z      = rv_q[2];
	assign rsp.res_scalar = rs_q;
	assign rsp.is_equal   = eq_q;
	assign rsp.div_zero   = dz_q;

`ifndef SYNTH
	a_eq_only: assert property (@(posedge clk) disable iff (!arst_n)
		vld_o_q && (cmd_q != CMD_EQ) |-> !eq_q)
		else $error("is_equal set for a non-compare op");

	a_dz_only: assert property (@(posedge clk) disable iff (!arst_n)
		vld_o_q && dz_q |-> (cmd_q == CMD_DIV) || (cmd_q == CMD_SDIV) || (cmd_q == CMD_NORM))
		else $error("div_zero set for a non-divide op");

	a_scalar_ops: assert property (@(posedge clk) disable iff (!arst_n)
		vld_o_q && ((cmd_q == CMD_DOT) || (cmd_q == CMD_LEN))
		|-> (rv_q[0] == '0) && (rv_q[1] == '0) && (rv_q[2] == '0))
		else $error("vector result on a scalar op");

	a_len_pos: assert property (@(posedge clk) disable iff (!arst_n)
		vld_o_q && ((cmd_q == CMD_LEN) || (cmd_q == CMD_NORM)) |-> !rs_q[WORD_W-1])
		else $error("negative length");
`endif

endmodule

// ===== sim/tb_if.sv =====
`timescale 1ns / 100ps

package tb_vec_pkg;
	import v3a_pkg::*;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		word_t a_x, a_y, a_z;
		word_t b_x, b_y, b_z;
		word_t scl;
	} vreq_t;

	typedef struct packed {
		word_t x, y, z, s;
		logic eq, dz;
	} vrsp_t;
endpackage

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import v3a_pkg::*;
	import tb_vec_pkg::*;

	localparam int LATENCY   = 83;
	localparam int N_RANDOM  = 1530;
	localparam int CYCLE_CAP = 400000;
	localparam int HOLD_OFF  = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #6 clk = ~clk;

	v3a_in_if  req();
	v3a_out_if rsp();

	vec3_alu dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req.sink),
		.rsp   (rsp.source)
	);

	// Expected responses, oldest first.
	vrsp_t expected_q[$];
	int errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int cycles = 0;
	bit stim_done = 1'b0;
	bit hold_on = 1'b0;
	int op_count[16];

	// ---------------- golden arithmetic ----------------
	localparam longint WMAX = 64'sd2147483647;
	localparam longint WMIN = -64'sd2147483648;

	function automatic longint clamp(input logic signed [127:0] v);
		if (v > WMAX) return WMAX;
		if (v < WMIN) return WMIN;
		return longint'(v);
	endfunction

	// product with low fraction bits dropped (floor), saturated
	function automatic word_t qmul(input word_t a, input word_t b);
		logic signed [127:0] p;
		p = 128'(a) * 128'(b);
		return word_t'(clamp(p >>> FRAC_W));
	endfunction

	function automatic word_t qdiv(input word_t a, input logic signed [127:0] d,
			inout logic dz);
		logic signed [127:0] n;
		if (d == 0) begin
			dz = 1'b1;
			if (a > 0) return WORD_MAX;
			if (a < 0) return WORD_MIN;
			return '0;
		end
		n = 128'(a) <<< FRAC_W;
		return word_t'(clamp(n / d)); // SV division truncates toward zero
	endfunction

	// cross term a*b - c*d, floored once after the exact difference
	function automatic word_t qcross(input word_t a, b, c, d);
		logic signed [127:0] t;
		t = 128'(a) * 128'(b) - 128'(c) * 128'(d);
		return word_t'(clamp(t >>> FRAC_W));
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [127:0] s);
		logic [127:0] r, b;
		r = 0;
		b = 128'd1 << 126;
		while (b > s) b = b >> 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s = s - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r[63:0];
	endfunction

	function automatic vrsp_t vec_predict(input vreq_t q);
		vrsp_t r;
		logic dz;
		logic signed [127:0] acc;
		logic [127:0] sq;
		logic [63:0] ln;
		r = '0;
		dz = 1'b0;
		case (q.cmd)
			CMD_ADD: begin
				r.x = word_t'(clamp(128'(q.a_x) + 128'(q.b_x)));
				r.y = word_t'(clamp(128'(q.a_y) + 128'(q.b_y)));
				r.z = word_t'(clamp(128'(q.a_z) + 128'(q.b_z)));
			end
			CMD_SUB: begin
				r.x = word_t'(clamp(128'(q.a_x) - 128'(q.b_x)));
				r.y = word_t'(clamp(128'(q.a_y) - 128'(q.b_y)));
				r.z = word_t'(clamp(128'(q.a_z) - 128'(q.b_z)));
			end
			CMD_MUL: begin
				r.x = qmul(q.a_x, q.b_x);
				r.y = qmul(q.a_y, q.b_y);
				r.z = qmul(q.a_z, q.b_z);
			end
			CMD_DIV: begin
				r.x = qdiv(q.a_x, 128'(q.b_x), dz);
				r.y = qdiv(q.a_y, 128'(q.b_y), dz);
				r.z = qdiv(q.a_z, 128'(q.b_z), dz);
			end
			CMD_SCALE: begin
				r.x = qmul(q.a_x, q.scl);
				r.y = qmul(q.a_y, q.scl);
				r.z = qmul(q.a_z, q.scl);
			end
			CMD_SDIV: begin
				r.x = qdiv(q.a_x, 128'(q.scl), dz);
				r.y = qdiv(q.a_y, 128'(q.scl), dz);
				r.z = qdiv(q.a_z, 128'(q.scl), dz);
			end
			CMD_NEG: begin
				r.x = word_t'(clamp(-128'(q.a_x)));
				r.y = word_t'(clamp(-128'(q.a_y)));
				r.z = word_t'(clamp(-128'(q.a_z)));
			end
			CMD_DOT: begin
				acc = 128'(q.a_x) * 128'(q.b_x) + 128'(q.a_y) * 128'(q.b_y)
					+ 128'(q.a_z) * 128'(q.b_z);
				r.s = word_t'(clamp(acc >>> FRAC_W));
			end
			CMD_CROSS: begin
				r.x = qcross(q.a_y, q.b_z, q.a_z, q.b_y);
				r.y = qcross(q.a_z, q.b_x, q.a_x, q.b_z);
				r.z = qcross(q.a_x, q.b_y, q.a_y, q.b_x);
			end
			CMD_LEN, CMD_NORM: begin
				sq = 128'(128'(q.a_x) * 128'(q.a_x)) + 128'(128'(q.a_y) * 128'(q.a_y))
					+ 128'(128'(q.a_z) * 128'(q.a_z));
				ln = int_sqrt(sq);
				r.s = (ln > 64'(WMAX)) ? WORD_MAX : word_t'(ln);
				if (q.cmd == CMD_NORM) begin
					r.x = qdiv(q.a_x, 128'(ln), dz);
					r.y = qdiv(q.a_y, 128'(ln), dz);
					r.z = qdiv(q.a_z, 128'(ln), dz);
				end
			end
			CMD_EQ: r.eq = (q.a_x == q.b_x) && (q.a_y == q.b_y) && (q.a_z == q.b_z);
			default: ;
		endcase
		r.dz = dz;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint exp);
		errors++;
		$display("[%0t] mismatch on response %0d, %s: got %h expected %h",
			$time, n_checked, what, got, exp);
	endtask

	// ---------------- directed table ----------------
	// Rows with a typed-in answer are checked against it; the rest use the predictor.
	typedef struct {
		vreq_t q;
		bit    fixed;
		vrsp_t r;
	} row_t;

	row_t table_rows[$];

	function automatic vreq_t mk(input logic [3:0] c, input word_t ax, ay, az, bx, by, bz,
			input word_t s);
		vreq_t q;
		q.cmd = c; q.a_x = ax; q.a_y = ay; q.a_z = az;
		q.b_x = bx; q.b_y = by; q.b_z = bz; q.scl = s;
		return q;
	endfunction

	function automatic vrsp_t rs(input word_t x, y, z, s, input logic e, d);
		vrsp_t r;
		r.x = x; r.y = y; r.z = z; r.s = s; r.eq = e; r.dz = d;
		return r;
	endfunction

	task automatic add_row(input vreq_t q, input bit fx, input vrsp_t r);
		row_t w;
		w.q = q; w.fixed = fx; w.r = r;
		table_rows.push_back(w);
	endtask

	task automatic build_table();
		word_t one, mx, mn;
		one = 32'sh0001_0000;
		mx = WORD_MAX;
		mn = WORD_MIN;
		// saturating add / sub at the extremes
		add_row(mk(CMD_ADD, mx, mn, one, mx, mn, one, 0), 1, rs(mx, mn, 2*one, 0, 0, 0));
		add_row(mk(CMD_SUB, mx, mn, 0, mn, mx, 0, 0), 1, rs(mx, mn, 0, 0, 0, 0));
		// negating the minimum saturates
		add_row(mk(CMD_NEG, mn, mx, 0, 0, 0, 0, 0), 1, rs(mx, mn + 1, 0, 0, 0, 0));
		add_row(mk(CMD_MUL, mx, mn, -one, mx, mn, 3*one, 0), 0, '0);
		add_row(mk(CMD_MUL, -1, 1, mn, 1, 1, 1, 0), 0, '0);
		// divide by zero: max, min and zero per dividend sign
		add_row(mk(CMD_DIV, one, -one, 0, 0, 0, 0, 0), 1, rs(mx, mn, 0, 0, 0, 1));
		add_row(mk(CMD_DIV, 7*one, mn, mx, 2*one, -1, 1, 0), 0, '0);
		add_row(mk(CMD_SCALE, mx, mn, one, 0, 0, 0, mn), 0, '0);
		add_row(mk(CMD_SDIV, one, -one, 0, 0, 0, 0, 0), 1, rs(mx, mn, 0, 0, 0, 1));
		add_row(mk(CMD_SDIV, mx, mn, 3*one, 0, 0, 0, -one), 0, '0);
		add_row(mk(CMD_DOT, mx, mx, mx, mx, mx, mx, 0), 0, '0);
		add_row(mk(CMD_DOT, mn, mn, mn, mx, mx, mx, 0), 0, '0);
		add_row(mk(CMD_CROSS, one, 0, 0, 0, one, 0, 0), 1, rs(0, 0, one, 0, 0, 0));
		add_row(mk(CMD_CROSS, mx, mn, mx, mn, mx, mn, 0), 0, '0);
		add_row(mk(CMD_LEN, 3*one, 4*one, 0, 0, 0, 0, 0), 1, rs(0, 0, 0, 5*one, 0, 0));
		add_row(mk(CMD_LEN, mn, mn, mn, 0, 0, 0, 0), 0, '0);
		// normalizing the zero vector flags divide by zero
		add_row(mk(CMD_NORM, 0, 0, 0, 0, 0, 0, 0), 1, rs(0, 0, 0, 0, 0, 1));
		add_row(mk(CMD_NORM, 3*one, 0, -4*one, 0, 0, 0, 0), 0, '0);
		add_row(mk(CMD_NORM, 1, 0, 0, 0, 0, 0, 0), 0, '0);
		add_row(mk(CMD_EQ, one, mn, mx, one, mn, mx, 0), 1, rs(0, 0, 0, 0, 1, 0));
		add_row(mk(CMD_EQ, one, mn, mx, one, mn, mx - 1, 0), 1, rs(0, 0, 0, 0, 0, 0));
		// unused opcodes give all zeros
		add_row(mk(4'd12, mx, mx, mx, mx, mx, mx, mx), 1, '0);
		add_row(mk(4'd15, -1, -1, -1, -1, -1, -1, -1), 1, '0);
	endtask

	// random operand with a bias toward edges and small values
	function automatic word_t rnd_word();
		case ($urandom_range(0, 9))
			0: return WORD_MAX;
			1: return WORD_MIN;
			2: return 0;
			3: return word_t'($urandom_range(0, 8)) <<< FRAC_W;
			4, 5: return word_t'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
			default: return word_t'($urandom);
		endcase
	endfunction

	function automatic vreq_t rnd_req();
		vreq_t q;
		q.cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
			: 4'($urandom_range(0, 11));
		q.a_x = rnd_word(); q.a_y = rnd_word(); q.a_z = rnd_word();
		q.b_x = rnd_word(); q.b_y = rnd_word(); q.b_z = rnd_word();
		q.scl = rnd_word();
		// some eq requests reuse operands so that equality comes up
		if (q.cmd == CMD_EQ && $urandom_range(0, 1)) begin
			q.b_x = q.a_x; q.b_y = q.a_y;
			q.b_z = $urandom_range(0, 1) ? q.a_z : q.a_z ^ (32'h1 << $urandom_range(0, 31));
		end
		return q;
	endfunction

	// ---------------- sender ----------------
	// Drives one transaction at falling edges, holding it until accepted.
	task automatic send(input vreq_t q, input vrsp_t exp);
		req.cmd <= q.cmd;
		req.a_x <= q.a_x; req.a_y <= q.a_y; req.a_z <= q.a_z;
		req.b_x <= q.b_x; req.b_y <= q.b_y; req.b_z <= q.b_z;
		req.scalar_in <= q.scl;
		req.valid <= 1'b1;
		do @(posedge clk); while (!req.ready);
		expected_q.push_back(exp);
		op_count[q.cmd]++;
		n_sent++;
		@(negedge clk);
	endtask

	task automatic idle_gap();
		int g;
		g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
		if (g > 0) begin
			req.valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	initial begin
		vreq_t q;
		int burst;
		req.valid <= 1'b0;
		req.cmd <= '0;
		req.a_x <= '0; req.a_y <= '0; req.a_z <= '0;
		req.b_x <= '0; req.b_y <= '0; req.b_z <= '0;
		req.scalar_in <= '0;
		build_table();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (table_rows[i]) begin
			send(table_rows[i].q, table_rows[i].fixed ? table_rows[i].r
				: vec_predict(table_rows[i].q));
			idle_gap();
		end
		// random traffic in bursts; the long receiver hold-off lands inside it
		for (int n = 0; n < N_RANDOM; ) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
				q = rnd_req();
				send(q, vec_predict(q));
			end
			idle_gap();
		end
		req.valid <= 1'b0;
		stim_done = 1'b1;
	end

	// ---------------- receiver ----------------
	// Stall pattern: phases of always-ready, random stalls and periodic stalls,
	// plus one long hold-off so the pipeline fills and req.ready drops.
	initial begin
		int mode;
		int len;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 2);
			len = $urandom_range(20, 200);
			for (int i = 0; i < len; i++) begin
				@(negedge clk);
				if (hold_on)
					rsp.ready <= 1'b0;
				else case (mode)
					0: rsp.ready <= 1'b1;
					1: rsp.ready <= ($urandom_range(0, 2) != 0);
					default: rsp.ready <= (i % 5 != 4);
				endcase
			end
		end
	end

	initial begin
		wait (n_sent >= 400);
		hold_on = 1'b1;
		repeat (HOLD_OFF) @(posedge clk);
		hold_on = 1'b0;
	end

	// ---------------- checker ----------------
	always @(posedge clk) begin
		vrsp_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_q.size() == 0) begin
				errors++;
				$display("[%0t] response with nothing outstanding", $time);
			end else begin
				e = expected_q.pop_front();
				if (rsp.res_x !== e.x) report_mismatch("res_x", rsp.res_x, e.x);
				if (rsp.res_y !== e.y) report_mismatch("res_y", rsp.res_y, e.y);
				if (rsp.res_z !== e.z) report_mismatch("res_z", rsp.res_z, e.z);
				if (rsp.res_scalar !== e.s)
					report_mismatch("res_scalar", rsp.res_scalar, e.s);
				if (rsp.is_equal !== e.eq) report_mismatch("is_equal", rsp.is_equal, e.eq);
				if (rsp.div_zero !== e.dz) report_mismatch("div_zero", rsp.div_zero, e.dz);
			end
			n_checked++;
		end
	end

	// ---------------- end of run ----------------
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("timeout after %0d cycles, %0d responses outstanding",
				cycles, expected_q.size());
			$display("** vec3_alu: FAILED **");
			$finish;
		end
	end

	initial begin
		wait (stim_done);
		wait (expected_q.size() == 0);
		repeat (2 * LATENCY) @(posedge clk);
		if (expected_q.size() != 0) begin
			errors++;
			$display("%0d responses never arrived", expected_q.size());
		end
		$display("sent %0d transactions over all 16 opcodes (add %0d, norm %0d, unused %0d)",
			n_sent, op_count[CMD_ADD], op_count[CMD_NORM],
			op_count[12] + op_count[13] + op_count[14] + op_count[15]);
		$display("checked %0d responses in %0d cycles, %0d mismatches",
			n_checked, cycles, errors);
		if (errors == 0)
			$display("** vec3_alu: PASSED **");
		else
			$display("** vec3_alu: FAILED **");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/v3a_pkg.sv
rtl/v3a_in_if.sv
rtl/v3a_out_if.sv
rtl/v3a_sqrt.sv
rtl/v3a_div.sv
rtl/vec3_alu.sv
sim/tb_if.sv
sim/testbench.sv
